>>> sv/segmented_reduce_mean_add_max_core_macros.svh
// Assertion macros for the segmented reduction core.
`ifndef SEGMENTED_REDUCE_MEAN_ADD_MAX_CORE_MACROS_SVH
`define SEGMENTED_REDUCE_MEAN_ADD_MAX_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define SRMAM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SRMAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SRMAM_ASSERT_SAME(label, ante, cons)

`define SRMAM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/srmam_pkg.sv
// Types, constants and helpers for the segmented reduction core.
`timescale 1ns / 1ps
`default_nettype none

package srmam_pkg;

    localparam int MAX_ELEMENTS = 65536;
    localparam int DIV_STEPS    = 48;
    localparam int CNT_W        = 6;
    localparam int ADDR_W       = 4;

    localparam logic [1:0] MODE_MEAN = 2'd0;
    localparam logic [1:0] MODE_SUM  = 2'd1;
    localparam logic [1:0] MODE_MAX  = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_COUNT = 2'd1;
    localparam logic [1:0] REG_ACCUM = 2'd2;

    localparam logic signed [48:0] VAL_HI = 49'sh0_0000_7FFF_FFFF;
    localparam logic signed [48:0] VAL_LO = -49'sh0_0000_8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_ABS,
        ST_DIV,
        ST_SIGN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic signed [31:0] elem_value;
        logic        [15:0] elem_position;
        logic               group_last;
        logic signed [31:0] prior_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] reduced_value;
        logic        [15:0] best_position;
    } out_word_t;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > VAL_HI)
            r = 32'sh7FFF_FFFF;
        else if (v < VAL_LO)
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/segmented_reduce_mean_add_max_core.sv
// Segmented sum, mean and maximum reduction core with shared adder and sequencer.
// Usage:
//   Elements enter on elem_valid / elem_stall / elem_word; one result word per
//   group leaves on res_valid / res_stall / res_word. Registers are set through
//   the APB port: reduce_mode at 0x0, group_count at 0x4, accumulate_onto at 0x8.
//   A word is taken at an edge with valid high and stall low.
//   Every step runs on one 49-bit add/subtract unit under a small sequencer.
//   An element that is not last in its group passes the accept and update steps.
//   The last element of a sum or max group goes from ST_ACC to ST_FIN, which
//   writes the result; mean first takes the sign off in ST_ABS, runs a restoring
//   divide in ST_DIV and puts the sign back in ST_SIGN before ST_FIN.
//   elem_stall is high while an element is in work.
//   A finished result sits in an output register; while res_stall holds it,
//   the core still takes and sums further elements, and only stops before
//   writing the next result.
//   Reset clears the running sum, maximum and position, drops any pending
//   result and sets mode to sum, group count to 1, accumulate off.
`timescale 1ns / 1ps
`default_nettype none

`include "segmented_reduce_mean_add_max_core_macros.svh"

module segmented_reduce_mean_add_max_core (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                elem_valid,
    output logic                               elem_stall,
    input  srmam_pkg::in_word_t                elem_word,
    output logic                               res_valid,
    input  wire                                res_stall,
    output srmam_pkg::out_word_t               res_word,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [srmam_pkg::ADDR_W-1:0]       paddr,
    input  wire  [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    srmam_pkg::state_t state_reg, state_next;

    logic [1:0]  mode_reg, mode_next;
    logic [16:0] count_reg, count_next;
    logic        accum_reg, accum_next;

    srmam_pkg::in_word_t word_reg;

    logic signed [47:0] sum_reg, sum_next;
    logic signed [31:0] max_reg, max_next;
    logic [15:0]        maxpos_reg, maxpos_next;
    logic               started_reg, started_next;

    logic signed [48:0] res_reg, res_next;
    logic [15:0]        pos_reg, pos_next;
    logic [47:0]        quo_reg, quo_next;
    logic [16:0]        rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic [srmam_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    srmam_pkg::out_word_t out_reg, out_next;
    logic                 res_valid_reg, res_valid_next;

    logic signed [48:0] add_a, add_b, add_y;
    logic               add_sub;

    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic [16:0] divisor;
    logic        is_max;
    logic        is_mean;
    logic        elem_take;
    logic        out_free;
    logic signed [47:0] sum_sat;
    logic        max_take;
    logic signed [31:0] max_new;
    logic [15:0] maxpos_new;
    logic signed [31:0] res_sat;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign cfg_idx    = paddr[3:2];
    assign elem_stall = (state_reg != srmam_pkg::ST_IDLE);
    assign elem_take  = elem_valid & ~elem_stall;
    assign res_valid  = res_valid_reg;
    assign res_word   = out_reg;
    assign out_free   = ~res_valid_reg | ~res_stall;
    assign is_max     = (mode_reg == srmam_pkg::MODE_MAX);
    assign is_mean    = (mode_reg == srmam_pkg::MODE_MEAN);

    always_comb
    begin
        if (count_reg == 17'd0)
            divisor = 17'd1;
        else if (count_reg > 17'(srmam_pkg::MAX_ELEMENTS))
            divisor = 17'(srmam_pkg::MAX_ELEMENTS);
        else
            divisor = count_reg;
    end

    always_comb
    begin
        case (cfg_idx)
            srmam_pkg::REG_MODE:  prdata = {30'd0, mode_reg};
            srmam_pkg::REG_COUNT: prdata = {15'd0, count_reg};
            srmam_pkg::REG_ACCUM: prdata = {31'd0, accum_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // shared add/subtract unit
    assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            srmam_pkg::ST_ACC:
            begin
                if (is_max)
                begin
                    add_a   = 49'(word_reg.elem_value);
                    add_b   = 49'(max_reg);
                    add_sub = 1'b1;
                end
                else
                begin
                    add_a = 49'(sum_reg);
                    add_b = 49'(word_reg.elem_value);
                end
            end
            srmam_pkg::ST_ABS:
            begin
                add_b   = res_reg;
                add_sub = 1'b1;
            end
            srmam_pkg::ST_DIV:
            begin
                add_a   = {31'd0, rem_reg, quo_reg[47]};
                add_b   = {32'd0, divisor};
                add_sub = 1'b1;
            end
            srmam_pkg::ST_SIGN:
            begin
                add_b   = {1'b0, quo_reg};
                add_sub = 1'b1;
            end
            srmam_pkg::ST_FIN:
            begin
                add_a = 49'(res_sat);
                add_b = 49'(word_reg.prior_value);
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (add_y[48] != add_y[47])
            sum_sat = add_y[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            sum_sat = add_y[47:0];
    end

    assign max_take   = ~started_reg | (~add_y[48] & (add_y != 49'sd0));
    assign max_new    = max_take ? word_reg.elem_value : max_reg;
    assign maxpos_new = max_take ? word_reg.elem_position : maxpos_reg;
    assign res_sat    = srmam_pkg::sat32(res_reg);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        accum_next     = accum_reg;
        sum_next       = sum_reg;
        max_next       = max_reg;
        maxpos_next    = maxpos_reg;
        started_next   = started_reg;
        res_next       = res_reg;
        pos_next       = pos_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        res_valid_next = res_valid_reg & res_stall;

        if (cfg_wr)
        begin
            case (cfg_idx)
                srmam_pkg::REG_MODE:  mode_next  = pwdata[1:0];
                srmam_pkg::REG_COUNT: count_next = pwdata[16:0];
                srmam_pkg::REG_ACCUM: accum_next = pwdata[0];
                default:              mode_next  = mode_reg;
            endcase
        end

        case (state_reg)
            srmam_pkg::ST_IDLE:
            begin
                if (elem_take)
                    state_next = srmam_pkg::ST_ACC;
            end
            srmam_pkg::ST_ACC:
            begin
                started_next = 1'b1;
                if (is_max)
                begin
                    max_next    = max_new;
                    maxpos_next = maxpos_new;
                end
                else
                    sum_next = sum_sat;
                if (!word_reg.group_last)
                    state_next = srmam_pkg::ST_IDLE;
                else
                begin
                    sum_next     = '0;
                    max_next     = '0;
                    maxpos_next  = '0;
                    started_next = 1'b0;
                    if (is_max)
                    begin
                        res_next   = 49'(max_new);
                        pos_next   = maxpos_new;
                        state_next = srmam_pkg::ST_FIN;
                    end
                    else
                    begin
                        res_next   = 49'(sum_sat);
                        pos_next   = '0;
                        state_next = is_mean ? srmam_pkg::ST_ABS : srmam_pkg::ST_FIN;
                    end
                end
            end
            srmam_pkg::ST_ABS:
            begin
                neg_next   = res_reg[48];
                quo_next   = res_reg[48] ? add_y[47:0] : res_reg[47:0];
                rem_next   = '0;
                cnt_next   = '0;
                state_next = srmam_pkg::ST_DIV;
            end
            srmam_pkg::ST_DIV:
            begin
                if (!add_y[48])
                begin
                    rem_next = add_y[16:0];
                    quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[15:0], quo_reg[47]};
                    quo_next = {quo_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == srmam_pkg::CNT_W'(srmam_pkg::DIV_STEPS - 1))
                    state_next = srmam_pkg::ST_SIGN;
            end
            srmam_pkg::ST_SIGN:
            begin
                res_next   = neg_reg ? add_y : {1'b0, quo_reg};
                state_next = srmam_pkg::ST_FIN;
            end
            srmam_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_next.reduced_value = accum_reg ? srmam_pkg::sat32(add_y) : res_sat;
                    out_next.best_position = pos_reg;
                    res_valid_next         = 1'b1;
                    state_next             = srmam_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srmam_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srmam_pkg::ST_IDLE;
            mode_reg      <= srmam_pkg::MODE_SUM;
            count_reg     <= 17'd1;
            accum_reg     <= 1'b0;
            sum_reg       <= '0;
            max_reg       <= '0;
            maxpos_reg    <= '0;
            started_reg   <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            accum_reg     <= accum_next;
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            maxpos_reg    <= maxpos_next;
            started_reg   <= started_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_take)
            word_reg <= elem_word;
        res_reg <= res_next;
        pos_reg <= pos_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    `SRMAM_ASSERT_NEXT(a_mid_group_returns, (state_reg == srmam_pkg::ST_ACC) && !word_reg.group_last, state_reg == srmam_pkg::ST_IDLE)
    `SRMAM_ASSERT_NEXT(a_group_end_clears, (state_reg == srmam_pkg::ST_ACC) && word_reg.group_last, !started_reg && (sum_reg == 48'sd0))
    `SRMAM_ASSERT_SAME(a_div_count_bound, state_reg == srmam_pkg::ST_DIV, cnt_reg < srmam_pkg::CNT_W'(srmam_pkg::DIV_STEPS))
    `SRMAM_ASSERT_SAME(a_pos_zero_unless_max, res_valid_reg && (mode_reg != srmam_pkg::MODE_MAX), out_reg.best_position == 16'd0)

endmodule

`default_nettype wire
